[design/clpl_pkg.sv]
// ----------------------------------------------------------------------------
// clpl_pkg
// Shared types and constants for the cumulative length paragraph lookup.
// ----------------------------------------------------------------------------
package clpl_pkg;

   // Default table depth
   localparam int CLPL_MAX_PARAGRAPHS_DEFAULT = 4096;

   // Field widths
   localparam int CLPL_CNT_W   = 13;
   localparam int CLPL_VAL_W   = 31;
   localparam int CLPL_IDX_W   = 16;
   localparam int CLPL_PIDX_W  = 13;
   localparam int CLPL_CSR_AW  = 3;
   localparam int CLPL_CSR_DW  = 32;

   // Register select (word address bit of the configuration port)
   localparam logic CSR_SEL_COUNT = 1'b0;
   localparam logic CSR_SEL_SIZE  = 1'b1;

   // Request codes
   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_FIND   = 2'd2
   } req_code_type;

   // Search engine states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LREAD,
      ST_LWAIT,
      ST_SCHECK,
      ST_SCMP,
      ST_RESULT
   } state_type;

   // Configuration seen by the engine
   typedef struct packed {
      logic [CLPL_CNT_W-1:0] count;
      logic [CLPL_CNT_W-1:0] size;
   } cfg_type;

endpackage

[design/clpl_mem.sv]
// ----------------------------------------------------------------------------
// clpl_mem
// Single-port length table with a registered read.
// ----------------------------------------------------------------------------
module clpl_mem
   import clpl_pkg::*;
#(
   parameter int DEPTH = CLPL_MAX_PARAGRAPHS_DEFAULT,
   parameter int AW    = $clog2(CLPL_MAX_PARAGRAPHS_DEFAULT)
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         addr,
   input  logic [CLPL_VAL_W-1:0] wdata,
   output logic [CLPL_VAL_W-1:0] rdata
);

   logic [CLPL_VAL_W-1:0] mem [DEPTH];
   logic [CLPL_VAL_W-1:0] rdata_ff;

   // Write or read the addressed entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/clpl_csr.sv]
// ----------------------------------------------------------------------------
// clpl_csr
// Configuration registers: paragraph count and table size.
// ----------------------------------------------------------------------------
module clpl_csr
   import clpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CLPL_CSR_AW-1:0] csr_paddr,
   input  logic [CLPL_CSR_DW-1:0] csr_pwdata,
   output logic [CLPL_CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_SEL_COUNT: cfg_ff.count <= csr_pwdata[CLPL_CNT_W-1:0];
            CSR_SEL_SIZE:  cfg_ff.size  <= csr_pwdata[CLPL_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_paddr[2])
         CSR_SEL_COUNT: csr_prdata = CLPL_CSR_DW'(cfg_ff.count);
         CSR_SEL_SIZE:  csr_prdata = CLPL_CSR_DW'(cfg_ff.size);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[design/clpl_search.sv]
// ----------------------------------------------------------------------------
// clpl_search
// Request sequencer: table writes, clamped lookups and binary search, with
// the result register on the output side.
// ----------------------------------------------------------------------------
module clpl_search
   import clpl_pkg::*;
#(
   parameter int MAX_PARAGRAPHS = CLPL_MAX_PARAGRAPHS_DEFAULT,
   parameter int AW             = $clog2(CLPL_MAX_PARAGRAPHS_DEFAULT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   // request side
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [CLPL_IDX_W-1:0]  req_index,
   input  logic [CLPL_VAL_W-1:0]  req_value,
   // result side
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CLPL_VAL_W-1:0]  rsp_length,
   output logic [CLPL_PIDX_W-1:0] rsp_index,
   // table port
   output logic                   mem_we,
   output logic [AW-1:0]          mem_addr,
   output logic [CLPL_VAL_W-1:0]  mem_wdata,
   input  logic [CLPL_VAL_W-1:0]  mem_rdata
);

   localparam int IW = AW + 2;
   localparam int LW = (IW > CLPL_IDX_W) ? IW : CLPL_IDX_W;
   localparam int CW = (AW + 1 > CLPL_CNT_W) ? AW + 1 : CLPL_CNT_W;

   function automatic logic [CLPL_PIDX_W-1:0] to_pidx(input logic signed [IW-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      return w[CLPL_PIDX_W-1:0];
   endfunction

   state_type                    state_ff, state_in;
   logic signed [CLPL_IDX_W-1:0] idx_ff, idx_in;
   logic [CLPL_VAL_W-1:0]        val_ff, val_in;
   logic signed [IW-1:0]         low_ff, low_in;
   logic signed [IW-1:0]         high_ff, high_in;
   logic [AW-1:0]                mid_ff, mid_in;
   logic [CLPL_VAL_W-1:0]        res_len_ff, res_len_in;
   logic [CLPL_PIDX_W-1:0]       res_idx_ff, res_idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CLPL_VAL_W-1:0]        rsp_len_ff, rsp_len_in;
   logic [CLPL_PIDX_W-1:0]       rsp_idx_ff, rsp_idx_in;

   logic [CW-1:0]          cnt_ext;
   logic [CW-1:0]          ecnt;
   logic signed [IW-1:0]   last;
   logic signed [LW-1:0]   idx_ext;
   logic signed [LW-1:0]   last_ext;
   logic signed [LW-1:0]   lk_clamp;
   logic [AW-1:0]          lk_addr;
   logic                   wr_ok;
   logic [AW-1:0]          first_mid;
   logic signed [IW-1:0]   mid_s;
   logic signed [IW-1:0]   nl;
   logic signed [IW-1:0]   nh;
   logic                   found;
   logic [IW:0]            sum;
   logic [AW-1:0]          next_mid;
   logic signed [IW-1:0]   ins_pt;

   // Effective count and last valid index
   always_comb begin
      cnt_ext = CW'(cfg.count);
      ecnt    = (cnt_ext > CW'(MAX_PARAGRAPHS)) ? CW'(MAX_PARAGRAPHS) : cnt_ext;
      last    = $signed({1'b0, ecnt[AW:0]}) - IW'(1);
   end

   // Lookup clamp and write range check
   always_comb begin
      idx_ext  = LW'(idx_ff);
      last_ext = LW'(last);
      lk_clamp = (idx_ext > last_ext) ? last_ext : idx_ext;
      if (lk_clamp < 0) begin
         lk_clamp = '0;
      end
      lk_addr   = lk_clamp[AW-1:0];
      wr_ok     = !idx_ext[LW-1] && (idx_ext < LW'(MAX_PARAGRAPHS));
      first_mid = last[AW:1];
   end

   // One probe of the search: narrow the bounds and pick the next midpoint
   always_comb begin
      mid_s = $signed({2'b00, mid_ff});
      nl    = low_ff;
      nh    = high_ff;
      found = 1'b0;
      if (mem_rdata > val_ff) begin
         nh = mid_s - IW'(1);
      end else if (mem_rdata < val_ff) begin
         nl = mid_s + IW'(1);
      end else begin
         found = 1'b1;
      end
      sum      = {nl[IW-1], nl} + {nh[IW-1], nh};
      next_mid = sum[AW:1];
      ins_pt   = (nl > last) ? last : nl;
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      res_len_in   = res_len_ff;
      res_idx_in   = res_idx_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = mid_ff;
      mem_wdata    = val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in     = $signed(req_index);
               val_in     = req_value;
               res_len_in = '0;
               res_idx_in = '0;
               case (req_type)
                  REQ_WRITE:  state_in = ST_WRITE;
                  REQ_LOOKUP: state_in = (cfg.size == '0) ? ST_RESULT : ST_LREAD;
                  REQ_FIND:   state_in = ST_SCHECK;
                  default:    state_in = ST_RESULT;
               endcase
            end
         end
         ST_WRITE: begin
            // drop writes outside the table
            if (wr_ok) begin
               mem_we   = 1'b1;
               mem_addr = idx_ext[AW-1:0];
            end
            state_in = ST_RESULT;
         end
         ST_LREAD: begin
            mem_addr = lk_addr;
            state_in = ST_LWAIT;
         end
         ST_LWAIT: begin
            res_len_in = mem_rdata;
            state_in   = ST_RESULT;
         end
         ST_SCHECK: begin
            low_in  = '0;
            high_in = last;
            if (last >= 0) begin
               mem_addr = first_mid;
               mid_in   = first_mid;
               state_in = ST_SCMP;
            end else begin
               // empty table
               res_idx_in = to_pidx(last);
               state_in   = ST_RESULT;
            end
         end
         ST_SCMP: begin
            if (found) begin
               res_idx_in = to_pidx(mid_s);
               state_in   = ST_RESULT;
            end else if (nl <= nh) begin
               low_in   = nl;
               high_in  = nh;
               mid_in   = next_mid;
               mem_addr = next_mid;
            end else begin
               res_idx_in = to_pidx(ins_pt);
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = res_len_ff;
               rsp_idx_in   = res_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      res_len_ff <= res_len_in;
      res_idx_ff <= res_idx_in;
      rsp_len_ff <= rsp_len_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_length = rsp_len_ff;
   assign rsp_index  = rsp_idx_ff;

endmodule

[design/cumulative_length_paragraph_lookup.sv]
// ----------------------------------------------------------------------------
// cumulative_length_paragraph_lookup
// Table of ascending cumulative lengths with indexed lookup and binary search.
// ----------------------------------------------------------------------------
// One item is worked at a time against a single-port table memory with a
// registered read. A write runs the write and result states, a length
// lookup the read, wait and result states (only the result state when
// table_size is zero, as does the unused request code), and a find the
// check state, then P probes, at most floor(log2(count)) + 1 (13 for a
// full 4096 entry table), then the result state; each probe compares the
// returned entry and issues the next read in the same cycle, so the single
// memory port paces the search. The finished result sits in an output
// register, so the next item is taken while it waits. The table holds no
// reset value: load each entry before it is read.
module cumulative_length_paragraph_lookup
   import clpl_pkg::*;
#(
   parameter int MAX_PARAGRAPHS = CLPL_MAX_PARAGRAPHS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] entry_index, [46:16] entry_value, [47] zero
   input  logic [47:0]            req_tdata,
   // [1:0] req_type
   input  logic [1:0]             req_tuser,
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [30:0] text_length, [43:31] paragraph_index, [47:44] zero
   output logic [47:0]            rsp_tdata,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CLPL_CSR_AW-1:0] csr_paddr,
   input  logic [CLPL_CSR_DW-1:0] csr_pwdata,
   output logic [CLPL_CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int AW = $clog2(MAX_PARAGRAPHS);

   cfg_type                cfg;
   logic                   mem_we;
   logic [AW-1:0]          mem_addr;
   logic [CLPL_VAL_W-1:0]  mem_wdata;
   logic [CLPL_VAL_W-1:0]  mem_rdata;
   logic [CLPL_VAL_W-1:0]  rsp_length;
   logic [CLPL_PIDX_W-1:0] rsp_index;

   clpl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   clpl_mem #(
      .DEPTH (MAX_PARAGRAPHS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   clpl_search #(
      .MAX_PARAGRAPHS (MAX_PARAGRAPHS),
      .AW             (AW)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_type   (req_tuser),
      .req_index  (req_tdata[15:0]),
      .req_value  (req_tdata[46:16]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_length (rsp_length),
      .rsp_index  (rsp_index),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   // Pack the result item
   assign rsp_tdata = {4'b0000, rsp_index, rsp_length};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cumulative length paragraph lookup.
// ----------------------------------------------------------------------------
// Sends write, lookup and find items over the request stream. A shadow copy
// of the length table and of both registers predicts every answer, and each
// result item is checked in order. A short directed table runs first. Random
// phases follow: each one sets the registers, extends an ascending table as
// far as the count needs, then mixes well-formed requests with out-of-range
// writes, wild indexes and the unused request code.
// ----------------------------------------------------------------------------
module tb;
   import clpl_pkg::*;

   localparam int DEPTH = CLPL_MAX_PARAGRAPHS_DEFAULT;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [CLPL_CSR_AW-1:0] ADDR_COUNT = {CSR_SEL_COUNT, 2'b00};
   localparam logic [CLPL_CSR_AW-1:0] ADDR_SIZE  = {CSR_SEL_SIZE, 2'b00};
   localparam logic [30:0] LEN_MAX   = 31'h7FFF_FFFF;
   localparam logic [12:0] PIDX_NONE = 13'h1FFF;
   localparam int REPORT_MAX = 10;
   localparam int TAIL_CYCLES = 40;
   // A slow find, a receiver stall and a sender gap make up the longest quiet
   // stretch of a good run, and the limit sits well above it.
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 14;

   typedef enum int {
      FLOW_FREE,
      FLOW_COIN,
      FLOW_PATTERN
   } flow_mode_type;

   typedef struct packed {
      logic [30:0] len;
      logic [12:0] pidx;
   } answer_type;

   typedef struct {
      bit          setting;
      logic [1:0]  code;
      int          idx;
      int unsigned val;
      bit          known;
      logic [30:0] len;
      logic [12:0] pidx;
   } stim_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata   = '0;
   logic [1:0]             req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [47:0]            rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CLPL_CSR_AW-1:0] csr_paddr   = '0;
   logic [CLPL_CSR_DW-1:0] csr_pwdata  = '0;
   logic [CLPL_CSR_DW-1:0] csr_prdata;
   logic                   csr_pready;

   // shadow state of the block
   logic [30:0] shadow_lengths [DEPTH];
   int unsigned shadow_count = 0;
   int unsigned shadow_size = 0;
   answer_type  awaited_answers [$];

   int           mismatches = 0;
   int           filled_upto = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   bit           valid_up = 1'b0;
   int           items_by_code [4] = '{0, 0, 0, 0};
   int           settings_done = 0;
   stim_row_type directed_rows [$];

   // probe path of a search that runs past the last entry of a full table
   int deep_path [13] = '{2047, 3071, 3583, 3839, 3967, 4031, 4063, 4079, 4087,
                          4091, 4093, 4094, 4095};

   // count, size, random items
   int unsigned phase_plan [PHASES][3] = '{
      '{1, 1, 60}, '{2, 8191, 60}, '{5, 3, 60}, '{0, 1, 40}, '{13, 0, 60},
      '{40, 40, 70}, '{200, 4096, 80}, '{400, 399, 90}, '{257, 400, 80},
      '{400, 8191, 80}, '{399, 0, 60}, '{150, 1, 60}, '{0, 0, 40},
      '{17, 2, 70}
   };

   always #5 clock = ~clock;

   cumulative_length_paragraph_lookup #(
      .MAX_PARAGRAPHS(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Work out the answer to one item and update the shadow table.
   function automatic answer_type table_answer(input logic [1:0] code,
                                               input logic signed [15:0] idx,
                                               input logic [30:0] val);
      answer_type ans;
      int         n;
      int         pos;
      int         lo;
      int         hi;
      int         mid;
      bit         hit;
      ans = '0;
      n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
      pos = idx;
      hit = 1'b0;
      case (code)
         REQ_WRITE: begin
            if (pos >= 0 && pos < DEPTH) shadow_lengths[pos] = val;
         end
         REQ_LOOKUP: begin
            if (shadow_size != 0) begin
               if (pos > n - 1) pos = n - 1;
               if (pos < 0) pos = 0;
               ans.len = shadow_lengths[pos];
            end
         end
         REQ_FIND: begin
            lo = 0;
            hi = n - 1;
            while (!hit && lo <= hi) begin
               mid = (lo + hi) >> 1;
               if (shadow_lengths[mid] > val) hi = mid - 1;
               else if (shadow_lengths[mid] < val) lo = mid + 1;
               else begin
                  hit = 1'b1;
                  lo = mid;
               end
            end
            // no match: insertion point, held to the last entry
            if (!hit && lo > n - 1) lo = n - 1;
            ans.pidx = lo[12:0];
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic void flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
   endfunction

   // Offer one item, hold it until taken, then log its answer.
   task automatic send_request(input logic [1:0] code, input logic [15:0] idx,
                               input logic [30:0] val, input bit known,
                               input logic [30:0] known_len, input logic [12:0] known_pidx);
      answer_type ans;
      if (gap_left > 0) repeat (gap_left) @(posedge clock);
      gap_left = 0;
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {1'b0, val, idx};
      valid_up = 1'b1;
      do @(posedge clock); while (!req_tready);
      ans = table_answer(code, idx, val);
      if (known) begin
         ans.len = known_len;
         ans.pidx = known_pidx;
      end
      awaited_answers = {awaited_answers, ans};
      items_by_code[code]++;
      // keep the burst going or drop valid for a gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
         gap_left = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Hold the sender until every answer is back.
   task automatic await_all_answers();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
      do @(posedge clock); while (awaited_answers.size() != 0);
   endtask

   task automatic csr_access(input logic [CLPL_CSR_AW-1:0] addr, input bit wr,
                             input logic [CLPL_CSR_DW-1:0] wdata,
                             output logic [CLPL_CSR_DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Drain, write both registers, read them back.
   task automatic apply_setting(input int unsigned count, input int unsigned size);
      logic [CLPL_CSR_DW-1:0] rd;
      int unsigned            want;
      await_all_answers();
      csr_access(ADDR_COUNT, 1'b1, CLPL_CSR_DW'(count), rd);
      csr_access(ADDR_SIZE, 1'b1, CLPL_CSR_DW'(size), rd);
      shadow_count = count & 32'h1FFF;
      shadow_size = size & 32'h1FFF;
      for (int r = 0; r < 2; r++) begin
         csr_access((r != 0) ? ADDR_SIZE : ADDR_COUNT, 1'b0, '0, rd);
         want = (r != 0) ? shadow_size : shadow_count;
         if (rd !== CLPL_CSR_DW'(want))
            flag_mismatch($sformatf("register at %0d reads %0d, wrote %0d",
                                    (r != 0) ? ADDR_SIZE : ADDR_COUNT, rd, want));
      end
      settings_done++;
   endtask

   task automatic add_row(input bit setting, input logic [1:0] code, input int idx,
                          input int unsigned val, input bit known,
                          input logic [30:0] len, input logic [12:0] pidx);
      stim_row_type row;
      row.setting = setting;
      row.code = code;
      row.idx = idx;
      row.val = val;
      row.known = known;
      row.len = len;
      row.pidx = pidx;
      directed_rows = {directed_rows, row};
   endtask

   // Check each result item against the oldest answer.
   answer_type seen_answer;
   answer_type due_answer;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_answer.len = rsp_tdata[30:0];
         seen_answer.pidx = rsp_tdata[43:31];
         if (awaited_answers.size() == 0) begin
            flag_mismatch($sformatf("result with nothing awaited: length %0d index %0d",
                                    seen_answer.len, seen_answer.pidx));
         end else begin
            due_answer = awaited_answers.pop_front();
            if (seen_answer.len !== due_answer.len)
               flag_mismatch($sformatf("text_length expected %0d got %0d",
                                       due_answer.len, seen_answer.len));
            if (seen_answer.pidx !== due_answer.pidx)
               flag_mismatch($sformatf("paragraph_index expected 0x%0h got 0x%0h",
                                       due_answer.pidx, seen_answer.pidx));
         end
      end
   end

   // Stall the result side: free flow, coin flips or a fixed pattern per window.
   logic [5:0]    stall_step = '0;
   flow_mode_type stall_mode = FLOW_FREE;
   logic [31:0]   stall_mask = '1;
   always @(posedge clock) begin
      stall_step <= stall_step + 6'd1;
      if (stall_step == '0) begin
         stall_mode <= flow_mode_type'($urandom_range(0, 2));
         stall_mask <= $urandom | 32'h1;
      end
      case (stall_mode)
         FLOW_FREE:    rsp_tready <= 1'b1;
         FLOW_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= stall_mask[stall_step[4:0]];
      endcase
   end

   // End the run when nothing moves for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      longint       step;
      longint       nxt;
      longint       lo;
      longint       hi;
      int           pick;
      int           sub;
      int           pos;
      int           n;
      int           nf;
      logic [1:0]   code;
      logic [15:0]  idx;
      logic [30:0]  val;
      logic [30:0]  tv;

      foreach (shadow_lengths[i]) shadow_lengths[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: size zero and an empty table
      add_row(0, REQ_LOOKUP, -32768, 0, 1, '0, '0);
      add_row(0, REQ_LOOKUP, 32767, LEN_MAX, 1, '0, '0);
      add_row(0, REQ_FIND, 0, 0, 1, '0, PIDX_NONE);
      add_row(0, REQ_FIND, 0, LEN_MAX, 1, '0, PIDX_NONE);
      add_row(0, REQ_WRITE, -1, LEN_MAX, 1, '0, '0);
      add_row(0, REQ_WRITE, DEPTH, 32'h2AAA_AAAA, 1, '0, '0);
      add_row(0, REQ_UNUSED, -1, LEN_MAX, 1, '0, '0);
      // four entries with a repeated length and the largest one
      add_row(1, REQ_WRITE, 4, 4, 0, '0, '0);
      add_row(0, REQ_WRITE, 0, 0, 0, '0, '0);
      add_row(0, REQ_WRITE, 1, 100, 0, '0, '0);
      add_row(0, REQ_WRITE, 2, 100, 0, '0, '0);
      add_row(0, REQ_WRITE, 3, LEN_MAX, 0, '0, '0);
      add_row(0, REQ_LOOKUP, -32768, 0, 1, '0, '0);
      add_row(0, REQ_LOOKUP, 32767, 0, 1, LEN_MAX, '0);
      add_row(0, REQ_LOOKUP, 1, 0, 0, '0, '0);
      add_row(0, REQ_FIND, 0, 100, 0, '0, '0);
      add_row(0, REQ_FIND, 0, LEN_MAX, 0, '0, '0);
      add_row(0, REQ_FIND, 0, 50, 0, '0, '0);
      add_row(0, REQ_FIND, 0, 0, 0, '0, '0);
      add_row(0, REQ_FIND, 0, LEN_MAX - 1, 0, '0, '0);
      // zero count: lookup clamps to entry 0, find answers none
      add_row(1, REQ_WRITE, 0, 4095, 0, '0, '0);
      add_row(0, REQ_LOOKUP, 5, 0, 0, '0, '0);
      add_row(0, REQ_FIND, -7, 7, 1, '0, PIDX_NONE);
      // size zero with two entries
      add_row(1, REQ_WRITE, 2, 0, 0, '0, '0);
      add_row(0, REQ_LOOKUP, 1, 0, 1, '0, '0);
      add_row(0, REQ_FIND, 0, 100, 0, '0, '0);
      // count above the depth: clamp to the last entry, longest search
      add_row(1, REQ_WRITE, 8191, 1, 0, '0, '0);
      foreach (deep_path[i]) add_row(0, REQ_WRITE, deep_path[i], 1000 + i, 0, '0, '0);
      add_row(0, REQ_LOOKUP, 32767, 0, 1, 31'd1012, '0);
      add_row(0, REQ_FIND, 0, LEN_MAX, 1, '0, 13'd4095);
      add_row(0, REQ_FIND, 0, 1005, 0, '0, '0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.setting)
            apply_setting(row.idx, row.val);
         else
            send_request(row.code, 16'(row.idx), 31'(row.val), row.known, row.len, row.pidx);
      end

      // random phases; reload the table from entry 0 first
      filled_upto = 0;
      for (int p = 0; p < PHASES; p++) begin
         apply_setting(phase_plan[p][0], phase_plan[p][1]);
         n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
         nf = (n == 0) ? 1 : n;

         // extend the ascending table up to the entries this count reads
         for (int e = filled_upto; e < nf; e++) begin
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                               : $urandom_range(0, 1 << 20);
            nxt = (e == 0) ? longint'($urandom_range(0, 40))
                           : longint'(shadow_lengths[e - 1]) + step;
            if (nxt > longint'(LEN_MAX)) nxt = longint'(LEN_MAX);
            send_request(REQ_WRITE, 16'(e), 31'(nxt), 1'b0, '0, '0);
         end
         if (nf > filled_upto) filled_upto = nf;

         for (int k = 0; k < int'(phase_plan[p][2]); k++) begin
            pick = $urandom_range(0, 99);
            idx = 16'($urandom);
            val = 31'($urandom);
            if (pick < 15) begin
               code = REQ_WRITE;
               sub = $urandom_range(0, 19);
               if (sub < 12) begin
                  // rewrite inside the count, keeping the order
                  pos = $urandom_range(0, nf - 1);
                  lo = (pos == 0) ? 0 : longint'(shadow_lengths[pos - 1]);
                  hi = (pos + 1 < filled_upto) ? longint'(shadow_lengths[pos + 1])
                                               : longint'(LEN_MAX);
                  val = (hi >= lo) ? 31'(lo + longint'($urandom) % (hi - lo + 1)) : 31'(lo);
                  idx = 16'(pos);
               end else if (sub < 17) begin
                  // outside the table: dropped
                  idx = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(32768, 65535))
                                                    : 16'($urandom_range(DEPTH, 32767));
               end else begin
                  // out-of-order value somewhere in the loaded part
                  idx = 16'($urandom_range(0, filled_upto - 1));
               end
            end else if (pick < 45) begin
               code = REQ_LOOKUP;
               if ($urandom_range(0, 9) < 7) idx = 16'($urandom_range(0, nf - 1));
            end else if (pick < 95) begin
               code = REQ_FIND;
               sub = $urandom_range(0, 9);
               tv = shadow_lengths[$urandom_range(0, nf - 1)];
               if (sub < 5) val = tv;
               else if (sub < 7) val = ($urandom_range(0, 1) != 0) ? tv + 31'd1 : tv - 31'd1;
            end else begin
               code = REQ_UNUSED;
            end
            send_request(code, idx, val, 1'b0, '0, '0);
            if ($urandom_range(0, 99) == 0) await_all_answers();
         end
      end

      await_all_answers();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d lookups, %0d finds, %0d unused-code items",
               items_by_code[REQ_WRITE], items_by_code[REQ_LOOKUP],
               items_by_code[REQ_FIND], items_by_code[REQ_UNUSED]);
      $display("over %0d register settings, table loaded to %0d entries, %0d mismatches",
               settings_done, filled_upto, mismatches);
      if (mismatches == 0 && awaited_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
